/* hdl/refusal_budget_breaker_table_assert.svh */
// Assertion macros shared by the breaker table modules.
`ifndef REFUSAL_BUDGET_BREAKER_TABLE_ASSERT_SVH
`define REFUSAL_BUDGET_BREAKER_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBBT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBBT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rbbt_pkg.sv */
// Package with the types, codes and sizes of the refusal breaker table.
package rbbt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BREAKER_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFUSAL_BUDGET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXHAUST_IS_ACTION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXHAUST_ACTION_ID = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_IS_ACTION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_ACTION_ID = 3'd5;

    // Verdict codes.
    localparam logic [1:0] VERDICT_SAT   = 2'd0;
    localparam logic [1:0] VERDICT_UNSAT = 2'd1;

    // Outcome codes.
    localparam logic [1:0] OUT_PASS   = 2'd0;
    localparam logic [1:0] OUT_RETRY  = 2'd1;
    localparam logic [1:0] OUT_DENY   = 2'd2;
    localparam logic [1:0] OUT_ACTION = 2'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [31:0] session;
        logic [63:0] signature;
        logic [15:0] refusals;
        logic        latched;
        logic        is_action;
        logic [7:0]  action;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic take_hit;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic issue_done;
        logic cmp_valid;
        logic cmp_match;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/rbbt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module rbbt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/rbbt_datapath.sv */
// Datapath: configuration registers, table memory, scan counters and result register.
`include "refusal_budget_breaker_table_assert.svh"

module rbbt_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rbbt_pkg::ctrl_cmd_t          cmd,
    output rbbt_pkg::dp_status_t         status,
    input  logic [31:0]                  s_session_key,
    input  logic [63:0]                  s_plan_sig,
    input  logic [1:0]                   s_verdict,
    input  logic                         cfg_valid,
    input  logic [rbbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbbt_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_outcome,
    output logic [15:0]                  m_refusal_count,
    output logic [15:0]                  m_budget_echo,
    output logic [7:0]                   m_action_id,
    output logic                         m_is_latched
);
    import rbbt_pkg::*;

    // Configuration registers.
    logic        breaker_enable_reg, breaker_enable_next;
    logic [15:0] refusal_budget_reg, refusal_budget_next;
    logic        exhaust_is_action_reg, exhaust_is_action_next;
    logic [7:0]  exhaust_action_id_reg, exhaust_action_id_next;
    logic        unknown_is_action_reg, unknown_is_action_next;
    logic [7:0]  unknown_action_id_reg, unknown_action_id_next;

    // Captured request.
    logic [31:0] sid_reg;
    logic [63:0] sig_reg;
    logic [1:0]  verdict_reg;

    // Scan and table state.
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              cmp_valid_reg;
    logic              hit_reg, hit_next;
    logic [ADDR_W-1:0] cmp_idx_reg;
    logic [ADDR_W-1:0] hit_idx_reg;
    entry_t            hit_data_reg;

    // Result register.
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  outcome_reg;
    logic [15:0] refusal_count_reg;
    logic [15:0] budget_echo_reg;
    logic [7:0]  action_id_reg;
    logic        is_latched_reg;

    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;
    logic               full;

    // Decision results.
    entry_t            base;
    entry_t            new_entry;
    logic              wr_c;
    logic              append_c;
    logic [ADDR_W-1:0] wr_addr_c;
    logic [15:0]       inc_c;
    logic [1:0]        res_outcome;
    logic [15:0]       res_count;
    logic [7:0]        res_action;
    logic              res_latched;

    always_comb begin
        breaker_enable_next    = breaker_enable_reg;
        refusal_budget_next    = refusal_budget_reg;
        exhaust_is_action_next = exhaust_is_action_reg;
        exhaust_action_id_next = exhaust_action_id_reg;
        unknown_is_action_next = unknown_is_action_reg;
        unknown_action_id_next = unknown_action_id_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BREAKER_ENABLE:    breaker_enable_next    = cfg_data[0];
                CFG_REFUSAL_BUDGET:    refusal_budget_next    = cfg_data;
                CFG_EXHAUST_IS_ACTION: exhaust_is_action_next = cfg_data[0];
                CFG_EXHAUST_ACTION_ID: exhaust_action_id_next = cfg_data[7:0];
                CFG_UNKNOWN_IS_ACTION: unknown_is_action_next = cfg_data[0];
                CFG_UNKNOWN_ACTION_ID: unknown_action_id_next = cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    rbbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.commit && wr_c),
        .wr_addr (wr_addr_c),
        .wr_data (new_entry),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));

    assign status.issue_done = (rd_idx_reg == count_reg);
    assign status.cmp_valid  = cmp_valid_reg;
    assign status.cmp_match  = (rd_entry.session == sid_reg) &&
                               (rd_entry.signature == sig_reg);
    assign status.out_free   = !m_valid_reg || m_ready;

    // Decision for the located (or fresh) entry.
    always_comb begin
        base           = hit_reg ? hit_data_reg : '0;
        base.session   = sid_reg;
        base.signature = sig_reg;
        new_entry      = base;
        wr_c           = 1'b0;
        append_c       = 1'b0;
        wr_addr_c      = hit_reg ? hit_idx_reg : count_reg[ADDR_W-1:0];
        inc_c          = (base.refusals == COUNT_MAX) ? base.refusals
                                                      : base.refusals + 16'd1;
        res_outcome    = OUT_PASS;
        res_count      = 16'd0;
        res_action     = 8'd0;
        res_latched    = 1'b0;
        priority if (verdict_reg == VERDICT_SAT) begin
            new_entry.refusals  = 16'd0;
            new_entry.latched   = 1'b0;
            new_entry.is_action = 1'b0;
            new_entry.action    = 8'd0;
            wr_c                = hit_reg;
        end else if (!hit_reg && full) begin
            // Table full: fail closed to the exhaustion disposition.
            res_outcome = exhaust_is_action_reg ? OUT_ACTION : OUT_DENY;
            res_action  = exhaust_is_action_reg ? exhaust_action_id_reg : 8'd0;
            res_latched = 1'b1;
        end else begin
            wr_c     = 1'b1;
            append_c = !hit_reg;
            priority if (base.latched) begin
                res_outcome = base.is_action ? OUT_ACTION : OUT_DENY;
                res_count   = base.refusals;
                res_action  = base.is_action ? base.action : 8'd0;
                res_latched = 1'b1;
            end else if (verdict_reg != VERDICT_UNSAT) begin
                new_entry.latched   = 1'b1;
                new_entry.is_action = unknown_is_action_reg;
                new_entry.action    = unknown_is_action_reg ? unknown_action_id_reg : 8'd0;
                res_outcome = unknown_is_action_reg ? OUT_ACTION : OUT_DENY;
                res_count   = base.refusals;
                res_action  = new_entry.action;
                res_latched = 1'b1;
            end else begin
                new_entry.refusals = inc_c;
                res_count          = inc_c;
                if (!breaker_enable_reg || (inc_c < refusal_budget_reg)) begin
                    res_outcome = OUT_RETRY;
                end else begin
                    new_entry.latched   = 1'b1;
                    new_entry.is_action = exhaust_is_action_reg;
                    new_entry.action    = exhaust_is_action_reg ? exhaust_action_id_reg
                                                                : 8'd0;
                    res_outcome = exhaust_is_action_reg ? OUT_ACTION : OUT_DENY;
                    res_action  = new_entry.action;
                    res_latched = 1'b1;
                end
            end
        end
    end

    always_comb begin
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load) begin
            rd_idx_next = '0;
            hit_next    = 1'b0;
        end
        if (cmd.issue) begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
        if (cmd.take_hit) begin
            hit_next = 1'b1;
        end
        if (cmd.commit) begin
            m_valid_next = 1'b1;
            if (append_c) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            breaker_enable_reg    <= 1'b1;
            refusal_budget_reg    <= 16'd3;
            exhaust_is_action_reg <= 1'b0;
            exhaust_action_id_reg <= 8'd0;
            unknown_is_action_reg <= 1'b0;
            unknown_action_id_reg <= 8'd0;
            count_reg             <= '0;
            rd_idx_reg            <= '0;
            cmp_valid_reg         <= 1'b0;
            hit_reg               <= 1'b0;
            m_valid_reg           <= 1'b0;
        end else begin
            breaker_enable_reg    <= breaker_enable_next;
            refusal_budget_reg    <= refusal_budget_next;
            exhaust_is_action_reg <= exhaust_is_action_next;
            exhaust_action_id_reg <= exhaust_action_id_next;
            unknown_is_action_reg <= unknown_is_action_next;
            unknown_action_id_reg <= unknown_action_id_next;
            count_reg             <= count_next;
            rd_idx_reg            <= rd_idx_next;
            cmp_valid_reg         <= cmd.issue;
            hit_reg               <= hit_next;
            m_valid_reg           <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sid_reg     <= s_session_key;
            sig_reg     <= s_plan_sig;
            verdict_reg <= s_verdict;
        end
        if (cmd.issue) begin
            cmp_idx_reg <= rd_idx_reg[ADDR_W-1:0];
        end
        if (cmd.take_hit) begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_data_reg <= rd_entry;
        end
        if (cmd.commit) begin
            outcome_reg       <= res_outcome;
            refusal_count_reg <= res_count;
            budget_echo_reg   <= refusal_budget_reg;
            action_id_reg     <= res_action;
            is_latched_reg    <= res_latched;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_outcome       = outcome_reg;
    assign m_refusal_count = refusal_count_reg;
    assign m_budget_echo   = budget_echo_reg;
    assign m_action_id     = action_id_reg;
    assign m_is_latched    = is_latched_reg;

    `RBBT_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
    `RBBT_ASSERT_NOW(a_commit_room, aclk, aresetn, cmd.commit,
        !m_valid_reg || m_ready, "result committed over a pending result")
    `RBBT_ASSERT_NOW(a_miss_full_scan, aclk, aresetn, cmd.commit && !hit_reg,
        rd_idx_reg == count_reg, "miss decided before every entry was read")

endmodule

/* hdl/rbbt_ctrl.sv */
// Controller state machine sequencing capture, table scan and decision.
`include "refusal_budget_breaker_table_assert.svh"

module rbbt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rbbt_pkg::dp_status_t status,
    output rbbt_pkg::ctrl_cmd_t  cmd
);
    import rbbt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (status.cmp_valid && status.cmp_match) begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_DECIDE;
                end else if (status.issue_done && !status.cmp_valid) begin
                    state_next = ST_DECIDE;
                end else begin
                    cmd.issue = !status.issue_done;
                end
            end
            ST_DECIDE: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `RBBT_ASSERT_NEXT(a_load_scan, aclk, aresetn, cmd.load,
        state_reg == ST_SCAN, "capture not followed by a scan")
    `RBBT_ASSERT_NEXT(a_hit_decide, aclk, aresetn, cmd.take_hit,
        state_reg == ST_DECIDE, "match not followed by a decision")
    `RBBT_ASSERT_NEXT(a_commit_idle, aclk, aresetn, cmd.commit,
        state_reg == ST_IDLE && s_ready, "controller not free after a commit")

endmodule

/* hdl/refusal_budget_breaker_table.sv */
// Top level of the refusal breaker table: controller, datapath and config port.
//
// Each request carries a session key, a 64-bit plan signature and a verdict,
// and produces exactly one result. The block handles one request at a time:
// it takes the request, then reads the table memory one entry per cycle,
// starting at entry 0, until the (session, signature) pair matches or all
// stored entries have been read, and then decides, writes the entry back
// (a missing pair is only appended when its verdict is not SAT and the table
// has room) and loads the result register. The single read port of the table
// and the registered read data that each compare waits on set the pace of
// the scan.
// The result register decouples the two sides: a new request is accepted
// while a result is still waiting, and the decision cycle only waits if that
// result has not been taken. No clearing pass is needed after reset, since
// only entries below the fill count are ever read. Configuration writes are
// always accepted (cfg_ready is tied high) and must only be issued while the
// block is idle; indexes past the last register are ignored.
module refusal_budget_breaker_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [31:0]                     s_session_key,
    input  logic [63:0]                     s_plan_sig,
    input  logic [1:0]                      s_verdict,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_outcome,
    output logic [15:0]                     m_refusal_count,
    output logic [15:0]                     m_budget_echo,
    output logic [7:0]                      m_action_id,
    output logic                            m_is_latched,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rbbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbbt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rbbt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    rbbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rbbt_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_session_key   (s_session_key),
        .s_plan_sig      (s_plan_sig),
        .s_verdict       (s_verdict),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_outcome       (m_outcome),
        .m_refusal_count (m_refusal_count),
        .m_budget_echo   (m_budget_echo),
        .m_action_id     (m_action_id),
        .m_is_latched    (m_is_latched)
    );

endmodule
